// ----- src/dmps_pkg.sv -----
package dmps_pkg;

  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned THROT_W   = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LATCH_W   = 7;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned STATE_W   = 3;
  localparam int unsigned NUM_RECOV = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_USE_MOTOR_ONE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_MOTOR_TWO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPPING_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPPING_THROTTLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTING_THROTTLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_TIMEOUT     = 3'd5;

  localparam logic [CFG_W-1:0] FAULT_TIMEOUT_RESET = 16'd25;

  // occurred-fault bits that clear at once: temperature and voltage
  localparam logic [LATCH_W-1:0] INSTANT_CLEAR_MASK = 7'b0111000;

  typedef enum logic [STATE_W-1:0] {
    MS_IDLE       = 3'd0,
    MS_STOP       = 3'd1,
    MS_RUN        = 3'd2,
    MS_FAULT_NOW  = 3'd3,
    MS_FAULT_OVER = 3'd4,
    MS_OTHER      = 3'd5
  } motor_state_t;

  typedef struct packed {
    logic              stop_request;
    logic              start_allowed;
    logic              powertrain_active;
    logic              powertrain_stopped;
    logic [MASK_W-1:0] standby_faults;
    logic [MASK_W-1:0] start_stop_faults;
    logic [MASK_W-1:0] run_faults;
  } eval_t;

endpackage

// ----- src/dmps_state_eval.sv -----
module dmps_state_eval (
  input  logic signed [dmps_pkg::SPEED_W-1:0]  speed_one,
  input  logic signed [dmps_pkg::SPEED_W-1:0]  speed_two,
  input  logic        [dmps_pkg::THROT_W-1:0]  throttle_level,
  input  logic                                 brake_pressed,
  input  logic                                 power_enabled,
  input  logic        [dmps_pkg::STATE_W-1:0]  state_one,
  input  logic        [dmps_pkg::STATE_W-1:0]  state_two,
  input  logic                                 use_motor_one,
  input  logic                                 use_motor_two,
  input  logic        [dmps_pkg::CFG_W-1:0]    stopping_speed,
  input  logic        [dmps_pkg::CFG_W-1:0]    stopping_throttle,
  input  logic        [dmps_pkg::CFG_W-1:0]    starting_throttle,
  output dmps_pkg::eval_t                      eval
);
  import dmps_pkg::*;

  logic [SPEED_W:0]  mag [2];
  logic              slow [2];
  logic              used [2];
  logic [STATE_W-1:0] st [2];
  logic              is_fault [2];
  logic              unexp_sb [2];
  logic              unexp_rn [2];
  logic              not_run [2];
  logic              not_stopped [2];

  assign used[0] = use_motor_one;
  assign used[1] = use_motor_two;
  assign st[0]   = state_one;
  assign st[1]   = state_two;

  // magnitude is one bit wider so that the most negative speed fits
  assign mag[0] = speed_one[SPEED_W-1] ? (17'h10000 - {1'b0, speed_one}) : {1'b0, speed_one};
  assign mag[1] = speed_two[SPEED_W-1] ? (17'h10000 - {1'b0, speed_two}) : {1'b0, speed_two};

  always_comb begin
    for (int m = 0; m < 2; m++) begin
      is_fault[m] = 1'b0;
      unexp_sb[m] = 1'b0;
      unexp_rn[m] = 1'b0;
      unique case (st[m])
        MS_IDLE: begin
          unexp_rn[m] = 1'b1;
        end
        MS_STOP: begin
          unexp_rn[m] = 1'b1;
        end
        MS_RUN: begin
          unexp_sb[m] = 1'b1;
        end
        MS_FAULT_NOW, MS_FAULT_OVER: begin
          is_fault[m] = 1'b1;
        end
        default: begin
          unexp_sb[m] = 1'b1;
          unexp_rn[m] = 1'b1;
        end
      endcase
      not_run[m]     = (st[m] != MS_RUN);
      not_stopped[m] = (st[m] != MS_IDLE) && !is_fault[m];
      // an unused motor counts as slow
      slow[m] = !used[m] || (mag[m] <= {1'b0, stopping_speed});
    end
  end

  always_comb begin
    eval = '0;
    eval.stop_request  = (slow[0] && slow[1] && (throttle_level < stopping_throttle))
                         || !power_enabled || brake_pressed;
    eval.start_allowed = (throttle_level > starting_throttle) && power_enabled
                         && !brake_pressed;
    eval.powertrain_active  = !(used[0] && not_run[0]) && !(used[1] && not_run[1]);
    eval.powertrain_stopped = !(used[0] && not_stopped[0]) && !(used[1] && not_stopped[1]);
    for (int m = 0; m < 2; m++) begin
      eval.standby_faults[2*m]      = used[m] && is_fault[m];
      eval.standby_faults[2*m+1]    = used[m] && unexp_sb[m];
      eval.start_stop_faults[2*m]   = used[m] && is_fault[m];
      eval.start_stop_faults[2*m+1] = 1'b0;
      eval.run_faults[2*m]          = used[m] && is_fault[m];
      eval.run_faults[2*m+1]        = used[m] && unexp_rn[m];
    end
  end

endmodule

// ----- src/dmps_recovery.sv -----
module dmps_recovery #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             update,
  input  logic                             used,
  input  logic                             fault_now,
  input  logic [dmps_pkg::CFG_W-1:0]       fault_timeout,
  input  logic [dmps_pkg::LATCH_W-1:0]     latched,
  output logic [dmps_pkg::LATCH_W-1:0]     latched_after
);
  import dmps_pkg::*;

  localparam int unsigned CMP_W = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;

  logic [COUNTER_WIDTH-1:0] counter      [NUM_RECOV];
  logic [COUNTER_WIDTH-1:0] counter_next [NUM_RECOV];
  logic                     recover_en;
  logic [LATCH_W-1:0]       cleared;

  // no recovery while either motor reports a current fault
  assign recover_en = used && !fault_now;

  always_comb begin
    cleared = latched;
    for (int b = 0; b < NUM_RECOV; b++) begin
      counter_next[b] = counter[b];
      if (latched[b]) begin
        if (CMP_W'(counter[b]) >= CMP_W'(fault_timeout)) begin
          cleared[b]      = 1'b0;
          counter_next[b] = '0;
        end else begin
          counter_next[b] = counter[b] + COUNTER_WIDTH'(1);
        end
      end
    end
    latched_after = recover_en ? (cleared & ~INSTANT_CLEAR_MASK) : latched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_RECOV; b++) counter[b] <= '0;
    end else if (update && recover_en) begin
      for (int b = 0; b < NUM_RECOV; b++) counter[b] <= counter_next[b];
    end
  end

endmodule

// ----- src/dual_motor_powertrain_supervisor_core.sv -----
// channel | handshake                | payload
// in      | in_valid / in_stall      | speed_one .. latched_two
// out     | out_valid / out_stall    | stop_request .. fault_acknowledge
// cfg     | cfg_write                | cfg_index, cfg_data
//
// one transaction per cycle unless out_stall holds the result register; each
// result passes the input register, then the result register and counter update
// the recovery counters advance when a transaction moves into the result register
// out_stall holds the result register; the input register still takes one more
// transaction, then in_stall rises until the result is taken
// reset clears valids and counters and sets configuration registers to their
// reset values
module dual_motor_powertrain_supervisor_core #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic        [dmps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [dmps_pkg::CFG_W-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [dmps_pkg::SPEED_W-1:0]  speed_one,
  input  logic signed [dmps_pkg::SPEED_W-1:0]  speed_two,
  input  logic        [dmps_pkg::THROT_W-1:0]  throttle_level,
  input  logic                                 brake_pressed,
  input  logic                                 power_enabled,
  input  logic        [dmps_pkg::STATE_W-1:0]  state_one,
  input  logic        [dmps_pkg::STATE_W-1:0]  state_two,
  input  logic                                 fault_now_one,
  input  logic                                 fault_now_two,
  input  logic        [dmps_pkg::LATCH_W-1:0]  latched_one,
  input  logic        [dmps_pkg::LATCH_W-1:0]  latched_two,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 stop_request,
  output logic                                 start_allowed,
  output logic                                 powertrain_active,
  output logic                                 powertrain_stopped,
  output logic        [dmps_pkg::MASK_W-1:0]   standby_faults,
  output logic        [dmps_pkg::MASK_W-1:0]   start_stop_faults,
  output logic        [dmps_pkg::MASK_W-1:0]   run_faults,
  output logic                                 fault_remaining,
  output logic                                 fault_acknowledge
);
  import dmps_pkg::*;

  logic               use_one;
  logic               use_two;
  logic [CFG_W-1:0]   stop_speed;
  logic [CFG_W-1:0]   stop_throttle;
  logic [CFG_W-1:0]   start_throttle;
  logic [CFG_W-1:0]   timeout;

  logic                      s1_valid;
  logic signed [SPEED_W-1:0] s1_speed_one;
  logic signed [SPEED_W-1:0] s1_speed_two;
  logic [THROT_W-1:0]        s1_throttle;
  logic                      s1_brake;
  logic                      s1_power;
  logic [STATE_W-1:0]        s1_state_one;
  logic [STATE_W-1:0]        s1_state_two;
  logic                      s1_fault_now;
  logic [LATCH_W-1:0]        s1_latched_one;
  logic [LATCH_W-1:0]        s1_latched_two;

  logic               s2_load;
  logic               s1_move;
  logic               in_take;
  eval_t              eval;
  logic [LATCH_W-1:0] lat_after_one;
  logic [LATCH_W-1:0] lat_after_two;
  logic               remain;

  assign s2_load  = !out_valid || !out_stall;
  assign s1_move  = s1_valid && s2_load;
  assign in_stall = s1_valid && !s2_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_one        <= 1'b1;
      use_two        <= 1'b0;
      stop_speed     <= '0;
      stop_throttle  <= '0;
      start_throttle <= '0;
      timeout        <= FAULT_TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_USE_MOTOR_ONE:     use_one        <= cfg_data[0];
        CFG_USE_MOTOR_TWO:     use_two        <= cfg_data[0];
        CFG_STOPPING_SPEED:    stop_speed     <= cfg_data;
        CFG_STOPPING_THROTTLE: stop_throttle  <= cfg_data;
        CFG_STARTING_THROTTLE: start_throttle <= cfg_data;
        CFG_FAULT_TIMEOUT:     timeout        <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_speed_one   <= speed_one;
      s1_speed_two   <= speed_two;
      s1_throttle    <= throttle_level;
      s1_brake       <= brake_pressed;
      s1_power       <= power_enabled;
      s1_state_one   <= state_one;
      s1_state_two   <= state_two;
      s1_fault_now   <= fault_now_one | fault_now_two;
      s1_latched_one <= latched_one;
      s1_latched_two <= latched_two;
    end
  end

  dmps_state_eval u_eval (
    .speed_one         (s1_speed_one),
    .speed_two         (s1_speed_two),
    .throttle_level    (s1_throttle),
    .brake_pressed     (s1_brake),
    .power_enabled     (s1_power),
    .state_one         (s1_state_one),
    .state_two         (s1_state_two),
    .use_motor_one     (use_one),
    .use_motor_two     (use_two),
    .stopping_speed    (stop_speed),
    .stopping_throttle (stop_throttle),
    .starting_throttle (start_throttle),
    .eval              (eval)
  );

  dmps_recovery #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_recov_one (
    .clk           (clk),
    .rst           (rst),
    .update        (s1_move),
    .used          (use_one),
    .fault_now     (s1_fault_now),
    .fault_timeout (timeout),
    .latched       (s1_latched_one),
    .latched_after (lat_after_one)
  );

  dmps_recovery #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_recov_two (
    .clk           (clk),
    .rst           (rst),
    .update        (s1_move),
    .used          (use_two),
    .fault_now     (s1_fault_now),
    .fault_timeout (timeout),
    .latched       (s1_latched_two),
    .latched_after (lat_after_two)
  );

  assign remain = |(lat_after_one | lat_after_two);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      stop_request       <= eval.stop_request;
      start_allowed      <= eval.start_allowed;
      powertrain_active  <= eval.powertrain_active;
      powertrain_stopped <= eval.powertrain_stopped;
      standby_faults     <= eval.standby_faults;
      start_stop_faults  <= eval.start_stop_faults;
      run_faults         <= eval.run_faults;
      fault_remaining    <= remain;
      fault_acknowledge  <= !remain;
    end
  end

endmodule

// ----- tb/dual_motor_powertrain_supervisor_core_tb.sv -----
`timescale 1ns / 1ps

module dual_motor_powertrain_supervisor_core_tb;
  import dmps_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 64;
  localparam int SETTLE_CYCLES = 6;

  typedef struct {
    logic signed [SPEED_W-1:0] speed_one;
    logic signed [SPEED_W-1:0] speed_two;
    logic [THROT_W-1:0]        throttle_level;
    logic                      brake_pressed;
    logic                      power_enabled;
    logic [STATE_W-1:0]        state_one;
    logic [STATE_W-1:0]        state_two;
    logic                      fault_now_one;
    logic                      fault_now_two;
    logic [LATCH_W-1:0]        latched_one;
    logic [LATCH_W-1:0]        latched_two;
  } tick_t;

  typedef struct {
    logic              stop_request;
    logic              start_allowed;
    logic              powertrain_active;
    logic              powertrain_stopped;
    logic [MASK_W-1:0] standby_faults;
    logic [MASK_W-1:0] start_stop_faults;
    logic [MASK_W-1:0] run_faults;
    logic              fault_remaining;
    logic              fault_acknowledge;
  } supervision_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [SPEED_W-1:0] speed_one = '0;
  logic signed [SPEED_W-1:0] speed_two = '0;
  logic [THROT_W-1:0]        throttle_level = '0;
  logic                      brake_pressed = 1'b0;
  logic                      power_enabled = 1'b0;
  logic [STATE_W-1:0]        state_one = '0;
  logic [STATE_W-1:0]        state_two = '0;
  logic                      fault_now_one = 1'b0;
  logic                      fault_now_two = 1'b0;
  logic [LATCH_W-1:0]        latched_one = '0;
  logic [LATCH_W-1:0]        latched_two = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      stop_request;
  logic                      start_allowed;
  logic                      powertrain_active;
  logic                      powertrain_stopped;
  logic [MASK_W-1:0]         standby_faults;
  logic [MASK_W-1:0]         start_stop_faults;
  logic [MASK_W-1:0]         run_faults;
  logic                      fault_remaining;
  logic                      fault_acknowledge;

  // shadow of the configuration registers and recovery counters
  logic               use_one = 1'b1;
  logic               use_two = 1'b0;
  logic [CFG_W-1:0]   stop_speed_lim = '0;
  logic [CFG_W-1:0]   stop_throttle_lim = '0;
  logic [CFG_W-1:0]   start_throttle_lim = '0;
  logic [CFG_W-1:0]   fault_timeout_ticks = FAULT_TIMEOUT_RESET;
  logic [15:0]        recovery_count [6] = '{default: '0};

  supervision_t pending_results [$];
  supervision_t want_now;
  logic [LATCH_W-1:0] held_one = '0;
  logic [LATCH_W-1:0] held_two = '0;
  int errors = 0;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_go = 0;
  int hold_seen = 0;
  int hold_left = 0;

  dual_motor_powertrain_supervisor_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .speed_one(speed_one),
    .speed_two(speed_two),
    .throttle_level(throttle_level),
    .brake_pressed(brake_pressed),
    .power_enabled(power_enabled),
    .state_one(state_one),
    .state_two(state_two),
    .fault_now_one(fault_now_one),
    .fault_now_two(fault_now_two),
    .latched_one(latched_one),
    .latched_two(latched_two),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stop_request(stop_request),
    .start_allowed(start_allowed),
    .powertrain_active(powertrain_active),
    .powertrain_stopped(powertrain_stopped),
    .standby_faults(standby_faults),
    .start_stop_faults(start_stop_faults),
    .run_faults(run_faults),
    .fault_remaining(fault_remaining),
    .fault_acknowledge(fault_acknowledge)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("dual_motor_powertrain_supervisor_core_tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic supervision_t supervise_tick(input tick_t t);
    supervision_t r;
    logic used [2];
    logic slow [2];
    logic [STATE_W-1:0] st [2];
    logic [LATCH_W-1:0] lat [2];
    logic signed [SPEED_W-1:0] spd [2];
    logic [SPEED_W:0] mag;
    logic is_fault;
    logic fnow;
    logic act;
    logic stp;
    logic [MASK_W-1:0] sb;
    logic [MASK_W-1:0] ss;
    logic [MASK_W-1:0] rn;
    int idx;
    used[0] = use_one;
    used[1] = use_two;
    st[0] = t.state_one;
    st[1] = t.state_two;
    lat[0] = t.latched_one;
    lat[1] = t.latched_two;
    spd[0] = t.speed_one;
    spd[1] = t.speed_two;
    fnow = t.fault_now_one | t.fault_now_two;
    sb = '0;
    ss = '0;
    rn = '0;
    act = 1'b1;
    stp = 1'b1;
    for (int m = 0; m < 2; m++) begin
      slow[m] = 1'b1;
      if (used[m]) begin
        // magnitude in 17 bits so that -32768 stays 32768
        mag = spd[m][SPEED_W-1] ? (17'h10000 - {1'b0, spd[m]}) : {1'b0, spd[m]};
        slow[m] = mag <= {1'b0, stop_speed_lim};
        is_fault = (st[m] == MS_FAULT_NOW) || (st[m] == MS_FAULT_OVER);
        if (is_fault) begin
          sb[2*m] = 1'b1;
          ss[2*m] = 1'b1;
          rn[2*m] = 1'b1;
        end else begin
          if (st[m] != MS_IDLE && st[m] != MS_STOP) sb[2*m+1] = 1'b1;
          if (st[m] != MS_RUN) rn[2*m+1] = 1'b1;
        end
        if (st[m] != MS_RUN) act = 1'b0;
        if (st[m] != MS_IDLE && !is_fault) stp = 1'b0;
        // any current fault on either motor freezes recovery
        if (!fnow) begin
          for (int b = 0; b < NUM_RECOV; b++) begin
            idx = 3 * m + b;
            if (lat[m][b]) begin
              if (recovery_count[idx] >= fault_timeout_ticks) begin
                lat[m][b] = 1'b0;
                recovery_count[idx] = '0;
              end else begin
                recovery_count[idx] = recovery_count[idx] + 16'd1;
              end
            end
          end
          lat[m] = lat[m] & ~INSTANT_CLEAR_MASK;
        end
      end
    end
    r.stop_request = (slow[0] && slow[1] && t.throttle_level < stop_throttle_lim)
                     || !t.power_enabled || t.brake_pressed;
    r.start_allowed = (t.throttle_level > start_throttle_lim) && t.power_enabled
                      && !t.brake_pressed;
    r.powertrain_active = act;
    r.powertrain_stopped = stp;
    r.standby_faults = sb;
    r.start_stop_faults = ss;
    r.run_faults = rn;
    r.fault_remaining = |(lat[0] | lat[1]);
    r.fault_acknowledge = ~r.fault_remaining;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing pending", $time);
      end else begin
        want_now = pending_results.pop_front();
        check_field("stop_request", 16'(want_now.stop_request), 16'(stop_request));
        check_field("start_allowed", 16'(want_now.start_allowed), 16'(start_allowed));
        check_field("powertrain_active", 16'(want_now.powertrain_active),
                    16'(powertrain_active));
        check_field("powertrain_stopped", 16'(want_now.powertrain_stopped),
                    16'(powertrain_stopped));
        check_field("standby_faults", 16'(want_now.standby_faults), 16'(standby_faults));
        check_field("start_stop_faults", 16'(want_now.start_stop_faults),
                    16'(start_stop_faults));
        check_field("run_faults", 16'(want_now.run_faults), 16'(run_faults));
        check_field("fault_remaining", 16'(want_now.fault_remaining),
                    16'(fault_remaining));
        check_field("fault_acknowledge", 16'(want_now.fault_acknowledge),
                    16'(fault_acknowledge));
      end
    end
  end

  // called right after a rising edge; returns at the edge that accepts the transaction
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    speed_one <= t.speed_one;
    speed_two <= t.speed_two;
    throttle_level <= t.throttle_level;
    brake_pressed <= t.brake_pressed;
    power_enabled <= t.power_enabled;
    state_one <= t.state_one;
    state_two <= t.state_two;
    fault_now_one <= t.fault_now_one;
    fault_now_two <= t.fault_now_two;
    latched_one <= t.latched_one;
    latched_two <= t.latched_two;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(supervise_tick(t));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_USE_MOTOR_ONE:     use_one = data[0];
      CFG_USE_MOTOR_TWO:     use_two = data[0];
      CFG_STOPPING_SPEED:    stop_speed_lim = data;
      CFG_STOPPING_THROTTLE: stop_throttle_lim = data;
      CFG_STARTING_THROTTLE: start_throttle_lim = data;
      CFG_FAULT_TIMEOUT:     fault_timeout_ticks = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_config(input bit u1, input bit u2, input int stop_spd,
                              input int stop_thr, input int start_thr, input int timeout);
    wait_idle();
    write_reg(CFG_USE_MOTOR_ONE, CFG_W'(u1));
    write_reg(CFG_USE_MOTOR_TWO, CFG_W'(u2));
    write_reg(CFG_STOPPING_SPEED, CFG_W'(stop_spd));
    write_reg(CFG_STOPPING_THROTTLE, CFG_W'(stop_thr));
    write_reg(CFG_STARTING_THROTTLE, CFG_W'(start_thr));
    write_reg(CFG_FAULT_TIMEOUT, CFG_W'(timeout));
  endtask

  function automatic tick_t tick(input int s1, input int s2, input int thr, input bit brk,
                                 input bit pwr, input int st1, input int st2, input bit f1,
                                 input bit f2, input int l1, input int l2);
    tick_t t;
    t.speed_one = SPEED_W'(s1);
    t.speed_two = SPEED_W'(s2);
    t.throttle_level = THROT_W'(thr);
    t.brake_pressed = brk;
    t.power_enabled = pwr;
    t.state_one = STATE_W'(st1);
    t.state_two = STATE_W'(st2);
    t.fault_now_one = f1;
    t.fault_now_two = f2;
    t.latched_one = LATCH_W'(l1);
    t.latched_two = LATCH_W'(l2);
    return t;
  endfunction

  // mostly around the stopping limit, sometimes anywhere or at the extremes
  function automatic logic [SPEED_W-1:0] pick_speed();
    int v;
    case ($urandom_range(3))
      0: v = $urandom;
      1, 2: begin
        v = int'(stop_speed_lim) + int'($urandom_range(4)) - 2;
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom_range(1) ? 32767 : -32768;
    endcase
    return SPEED_W'(v);
  endfunction

  function automatic logic [THROT_W-1:0] pick_throttle();
    int v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = int'(stop_throttle_lim) + int'($urandom_range(4)) - 2;
      2: v = int'(start_throttle_lim) + int'($urandom_range(4)) - 2;
      default: v = $urandom_range(1) ? 65535 : 0;
    endcase
    return THROT_W'(v);
  endfunction

  function automatic logic [STATE_W-1:0] pick_state();
    if ($urandom_range(9) == 0) return STATE_W'($urandom_range(7));
    return STATE_W'($urandom_range(5));
  endfunction

  // occurred-fault words persist across ticks like real firmware, so the
  // recovery counters get to run up to the timeout
  function automatic tick_t random_tick();
    tick_t t;
    if ($urandom_range(9) == 0)
      held_one = LATCH_W'($urandom_range(127)) & ($urandom_range(1) ? 7'h07 : 7'h7F);
    if ($urandom_range(9) == 0)
      held_two = LATCH_W'($urandom_range(127)) & ($urandom_range(1) ? 7'h07 : 7'h7F);
    t.speed_one = pick_speed();
    t.speed_two = pick_speed();
    t.throttle_level = pick_throttle();
    t.brake_pressed = ($urandom_range(3) == 0);
    t.power_enabled = ($urandom_range(5) != 0);
    t.state_one = pick_state();
    t.state_two = pick_state();
    t.fault_now_one = ($urandom_range(99) < 12);
    t.fault_now_two = ($urandom_range(99) < 12);
    t.latched_one = held_one;
    t.latched_two = held_two;
    // noise: unrelated words on a few ticks
    if ($urandom_range(99) < 15) begin
      t.latched_one = LATCH_W'($urandom_range(127));
      t.latched_two = LATCH_W'($urandom_range(127));
      t.fault_now_one = 1'($urandom_range(1));
      t.fault_now_two = 1'($urandom_range(1));
    end
    return t;
  endfunction

  task automatic test_reset_values();
    send_tick(tick(0, 0, 0, 0, 1, MS_IDLE, MS_IDLE, 0, 0, 0, 0));
    send_tick(tick(-32768, 32767, 65535, 0, 1, MS_RUN, MS_OTHER, 0, 0, 7'h7F, 7'h7F));
  endtask

  task automatic test_field_extremes();
    apply_config(1, 1, 32767, 1000, 2000, 2);
    send_tick(tick(-32768, 5, 0, 0, 1, MS_RUN, MS_RUN, 0, 0, 0, 0));
    send_tick(tick(32767, -32767, 999, 0, 1, MS_IDLE, MS_STOP, 0, 0, 0, 0));
    send_tick(tick(0, 0, 65535, 1, 1, MS_RUN, MS_IDLE, 0, 0, 0, 0));
    send_tick(tick(0, 0, 2001, 0, 0, MS_FAULT_OVER, MS_RUN, 0, 0, 0, 0));
    send_tick(tick(0, 0, 2001, 0, 1, MS_RUN, MS_RUN, 0, 0, 0, 0));
    // every state code on both motors, including the undefined ones,
    // while all occurred bits run through recovery
    for (int i = 0; i < 8; i++)
      send_tick(tick(100, -100, 1500, 0, 1, i, 7 - i, 0, 0, 7'h7F, 7'h7F));
    // a current fault on the other motor freezes recovery
    send_tick(tick(0, 0, 1500, 0, 1, MS_FAULT_NOW, MS_RUN, 0, 1, 7'h07, 7'h07));
    send_tick(tick(0, 0, 1500, 0, 1, MS_STOP, MS_FAULT_NOW, 1, 0, 7'h3F, 7'h40));
    wait_idle();
    write_reg(CFG_STOPPING_SPEED, 16'd32768);
    send_tick(tick(-32768, -32768, 0, 0, 1, MS_IDLE, MS_IDLE, 0, 0, 0, 0));
  endtask

  task automatic test_timeout_lowered();
    wait_idle();
    write_reg(CFG_FAULT_TIMEOUT, 16'd25);
    repeat (6) send_tick(tick(0, 0, 0, 0, 1, MS_RUN, MS_RUN, 0, 0, 7'h01, 7'h02));
    wait_idle();
    write_reg(CFG_FAULT_TIMEOUT, 16'd3);
    repeat (2) send_tick(tick(0, 0, 0, 0, 1, MS_RUN, MS_RUN, 0, 0, 7'h01, 7'h02));
  endtask

  task automatic test_random_traffic(input int count, input int gap, input int stall);
    gap_pct = gap;
    stall_pct = stall;
    repeat (count) send_tick(random_tick());
    gap_pct = 0;
    stall_pct = 0;
  endtask

  // long receiver hold-off while the sender keeps offering transactions
  task automatic test_backpressure();
    apply_config(1, 1, 500, 300, 600, 4);
    gap_pct = 0;
    stall_pct = 0;
    hold_go <= hold_go + 1;
    repeat (30) send_tick(random_tick());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_field_extremes();
    test_timeout_lowered();
    apply_config(1, 1, 200, 1000, 2000, 3);
    test_random_traffic(150, 0, 0);
    apply_config(1, 0, 0, 0, 65535, 0);
    test_random_traffic(150, 46, 0);
    apply_config(0, 1, 32768, 65535, 0, 65535);
    test_random_traffic(150, 0, 46);
    apply_config(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(32768),
                 $urandom_range(65535), $urandom_range(65535), $urandom_range(6));
    test_random_traffic(150, 6, 6);
    apply_config(0, 0, 100, 500, 500, 1);
    test_random_traffic(100, 46, 46);
    apply_config(1, 1, $urandom_range(32768), $urandom_range(65535),
                 $urandom_range(65535), $urandom_range(3));
    test_random_traffic(100, 0, 0);
    test_backpressure();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("dual_motor_powertrain_supervisor_core_tb: PASS");
    end else begin
      $display("dual_motor_powertrain_supervisor_core_tb: FAIL");
    end
    $finish;
  end

endmodule
